FILE: rtl/mau_pkg.sv
// mau_pkg: types and constants for the modular arithmetic unit
// no dependencies
`default_nettype none
package mau_pkg;
    localparam int MODULUS_WIDTH_DEF = 31;
    localparam logic [30:0] MOD_RESET = 31'd1000000007;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDA,
        ST_REDB,
        ST_OP,
        ST_EU_DIV,
        ST_EU_UPD,
        ST_MUL_Q,
        ST_FIXU,
        ST_DIVMUL,
        ST_FINAL,
        ST_OUT
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic start;
    } div_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/mau_divider.sv
// mau_divider: restoring bit-serial divider, 128-bit dividend by modulus-wide divisor
// depends on mau_pkg
`default_nettype none
module mau_divider #(
    parameter int W = mau_pkg::MODULUS_WIDTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mau_pkg::div_ctl_t ctl,
    input  wire logic [127:0]   dividend,
    input  wire logic [W-1:0]   divisor,
    output logic                busy,
    output logic [127:0]        quotient,
    output logic [W-1:0]        remainder
);
    logic [127:0] q_reg, q_next;
    logic [W:0]   r_reg, r_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [W:0]   shifted;
    logic [W:0]   diff;

    // one quotient bit per cycle
    always_comb
    begin
        shifted   = {r_reg[W-1:0], q_reg[127]};
        diff      = shifted - {1'b0, divisor};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 8'd128;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                r_next = diff;
                q_next = {q_reg[126:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[126:0], 1'b0};
            end
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[W-1:0];
endmodule
`default_nettype wire

FILE: rtl/modular_arithmetic_unit.sv
// modular_arithmetic_unit: top level, sequencer around one shared divider
// depends on mau_pkg, mau_divider
//
// usage: one beat on s_axis (tdata = action, operand_a, operand_b from bit 0
// up, action in bits 1:0) is taken when s_axis_tready is high; one beat
// (residue) leaves on m_axis. The modulus register is written through
// cfg_we / cfg_data, resets to 1000000007 and must be written by the user
// only while the block is idle; the block itself does not enforce this.
// All reductions run through a single bit-serial divider. A divider pass
// starts the divider, computes the 128 quotient bits and ends with a done
// check. Add, subtract and multiply take three passes (operand a, operand
// b, result) before the result beat is offered. Divide takes two operand
// passes, the first Euclid swap, then for each further Euclid step a pass,
// a multiply state and an update state (up to about 45 steps), and two
// more passes for the coefficient fix-up and the final multiply. With a
// zero modulus the sequencer skips all divider passes.
// s_axis_tready is low from acceptance until the result beat is taken and
// rises in the next cycle; a stalled receiver holds the result beat in the
// output register. Reset clears the sequencer and output valid.
`default_nettype none
module modular_arithmetic_unit #(
    parameter int MODULUS_WIDTH = mau_pkg::MODULUS_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [30:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action[1:0], operand_a[65:2], operand_b[129:66], zero fill
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // residue[30:0], zero fill
    output logic [31:0]       m_axis_tdata
);
    localparam int W = MODULUS_WIDTH;

    mau_pkg::state_t state_reg, state_next;
    logic [W-1:0] mod_reg;
    logic [1:0]   act_reg;
    logic [63:0]  opa_reg, opb_reg;
    logic [W-1:0] a_reg, b_reg;
    // euclid values: x, y at most modulus; u, w two's complement signed, magnitude bounded by modulus
    logic [W-1:0] x_reg, y_reg;
    logic signed [W+1:0] u_reg, w_reg;
    logic [W-1:0] res_reg;
    logic [W-1:0] res_next;
    logic         out_v_reg;

    mau_pkg::div_ctl_t dctl;
    logic [127:0] dividend;
    logic         dbusy;
    logic [127:0] dq;
    logic [W-1:0] drem;
    logic         started_reg;

    mau_divider #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dividend),
        .divisor(state_reg == mau_pkg::ST_EU_DIV ? y_reg : mod_reg),
        .busy(dbusy), .quotient(dq), .remainder(drem)
    );

    logic mzero;
    assign mzero = (mod_reg == '0);
    logic div_done;
    assign div_done = started_reg && !dbusy && !dctl.start;

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= mau_pkg::MOD_RESET[W-1:0];
        else if (cfg_we)
            mod_reg <= cfg_data[W-1:0];
    end

    // magnitude of a signed operand
    function automatic logic [63:0] mag(input logic [63:0] v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

    // reduced value of a signed operand from a remainder
    function automatic logic [W-1:0] fixneg(input logic neg, input logic [W-1:0] r,
                                             input logic [W-1:0] m);
        fixneg = (neg && r != '0) ? (m - r) : r;
    endfunction

    logic [W:0] sum;
    logic [2*W-1:0] prod;
    logic [W+1:0] umag;

    // divider operand select and start
    always_comb
    begin
        dctl.start = 1'b0;
        dividend   = '0;
        sum        = '0;
        prod       = '0;
        umag       = u_reg[W+1] ? $unsigned(-u_reg) : $unsigned(u_reg);
        case (state_reg)
            mau_pkg::ST_REDA:
                dividend = {64'd0, mag(opa_reg)};
            mau_pkg::ST_REDB:
                dividend = {64'd0, mag(opb_reg)};
            mau_pkg::ST_OP:
            begin
                case (act_reg)
                    mau_pkg::ACT_ADD: sum = {1'b0, a_reg} + {1'b0, b_reg};
                    mau_pkg::ACT_SUB: sum = {1'b0, a_reg} + {1'b0, mod_reg} - {1'b0, b_reg};
                    default:          sum = '0;
                endcase
                prod = a_reg * b_reg;
                dividend = (act_reg == mau_pkg::ACT_MUL) ? 128'(prod) : 128'(sum);
            end
            mau_pkg::ST_EU_DIV:
                dividend = 128'(x_reg);
            mau_pkg::ST_FIXU:
                dividend = 128'(umag);
            mau_pkg::ST_DIVMUL:
            begin
                prod = a_reg * u_reg[W-1:0];
                dividend = 128'(prod);
            end
            default:
                dividend = '0;
        endcase
        if (!started_reg && (state_reg == mau_pkg::ST_REDA || state_reg == mau_pkg::ST_REDB
            || (state_reg == mau_pkg::ST_OP && act_reg != mau_pkg::ACT_DIV)
            || state_reg == mau_pkg::ST_EU_DIV || state_reg == mau_pkg::ST_FIXU
            || state_reg == mau_pkg::ST_DIVMUL))
            dctl.start = 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mau_pkg::ST_IDLE:
                if (s_axis_tvalid)
                    state_next = mzero ? mau_pkg::ST_FINAL : mau_pkg::ST_REDA;
            mau_pkg::ST_REDA:
                if (div_done) state_next = mau_pkg::ST_REDB;
            mau_pkg::ST_REDB:
                if (div_done) state_next = mau_pkg::ST_OP;
            mau_pkg::ST_OP:
                if (act_reg == mau_pkg::ACT_DIV)
                    state_next = (x_reg == '0) ? mau_pkg::ST_FIXU : mau_pkg::ST_EU_DIV;
                else if (div_done)
                    state_next = mau_pkg::ST_FINAL;
            mau_pkg::ST_EU_DIV:
                if (div_done) state_next = mau_pkg::ST_MUL_Q;
            mau_pkg::ST_MUL_Q:
                state_next = mau_pkg::ST_EU_UPD;
            mau_pkg::ST_EU_UPD:
                state_next = (drem == '0) ? mau_pkg::ST_FIXU : mau_pkg::ST_EU_DIV;
            mau_pkg::ST_FIXU:
                if (div_done) state_next = mau_pkg::ST_DIVMUL;
            mau_pkg::ST_DIVMUL:
                if (div_done) state_next = mau_pkg::ST_FINAL;
            mau_pkg::ST_FINAL:
                state_next = mau_pkg::ST_OUT;
            mau_pkg::ST_OUT:
                if (m_axis_tready) state_next = mau_pkg::ST_IDLE;
            default:
                state_next = mau_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = (state_reg == mau_pkg::ST_IDLE);
        m_axis_tvalid = out_v_reg;
        m_axis_tdata  = 32'(res_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mau_pkg::ST_IDLE;
            started_reg <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                started_reg <= 1'b0;
            else if (dctl.start)
                started_reg <= 1'b1;
            if (state_reg == mau_pkg::ST_FINAL)
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
        end
    end

    // datapath registers
    always_comb
    begin
        res_next = res_reg;
        if (state_reg == mau_pkg::ST_IDLE)
            res_next = '0;
        else if (div_done && (state_reg == mau_pkg::ST_OP || state_reg == mau_pkg::ST_DIVMUL))
            res_next = drem;
    end

    logic signed [W+1:0] qw_reg;
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        case (state_reg)
            mau_pkg::ST_IDLE:
                if (s_axis_tvalid)
                begin
                    act_reg <= s_axis_tdata[1:0];
                    opa_reg <= s_axis_tdata[65:2];
                    opb_reg <= s_axis_tdata[129:66];
                end
            mau_pkg::ST_REDA:
                if (div_done) a_reg <= fixneg(opa_reg[63], drem, mod_reg);
            mau_pkg::ST_REDB:
                if (div_done)
                begin
                    b_reg <= fixneg(opb_reg[63], drem, mod_reg);
                    x_reg <= fixneg(opb_reg[63], drem, mod_reg);
                    y_reg <= mod_reg;
                    u_reg <= (W+2)'(1);
                    w_reg <= '0;
                end
            mau_pkg::ST_OP:
                if (act_reg == mau_pkg::ACT_DIV)
                begin
                    // first step: q = d / m = 0, swap; a zero d ends with coefficient 0
                    y_reg <= x_reg;
                    x_reg <= mod_reg;
                    u_reg <= '0;
                    w_reg <= (W+2)'(1);
                end
            mau_pkg::ST_MUL_Q:
                qw_reg <= (W+2)'($signed({1'b0, dq[W-1:0]}) * w_reg);
            mau_pkg::ST_EU_UPD:
            begin
                x_reg <= y_reg;
                y_reg <= drem;
                u_reg <= w_reg;
                w_reg <= u_reg - qw_reg;
            end
            mau_pkg::ST_FIXU:
                if (div_done)
                    u_reg <= (W+2)'(fixneg(u_reg[W+1], drem, mod_reg));
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/mau_checker.sv
// mau_checker: port-level assertions for the modular arithmetic unit
// depends on modular_arithmetic_unit (bound to it)
`default_nettype none
module mau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);
    // no new beat taken while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready with result pending");
    // accepted beat drops ready
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
    // result holds under stall
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
    // fill bit is zero
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[31]) else $error("fill bit set");
endmodule

bind modular_arithmetic_unit mau_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

FILE: bench/modular_arithmetic_unit_test.sv
// modular_arithmetic_unit_test: self-checking bench for the modular arithmetic unit
// drives operand beats from a queue, predicts each residue, checks every result beat
// depends on mau_pkg and modular_arithmetic_unit
`default_nettype none
module modular_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int ITEMS_PER_SET  = 143;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct {
        mau_pkg::action_t act;
        logic [63:0]      opa;
        logic [63:0]      opb;
    } operand_beat_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [30:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;

    operand_beat_t pending_beats[$];
    logic [30:0]   expected_residues[$];
    logic [30:0]   modulus_copy;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_left;
    logic          hold_request;
    int            failures;
    int            quiet_cycles;

    modular_arithmetic_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock, 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // euclidean reduction of a two's complement value
    function automatic logic [63:0] euclid_mod(logic [63:0] raw, logic [63:0] m);
        logic [63:0] mag;
        logic [63:0] r;
        mag = raw[63] ? (64'd0 - raw) : raw;
        r = mag % m;
        if (raw[63] && r != 64'd0)
            r = m - r;
        return r;
    endfunction

    // bezout coefficient of d against m, reduced into the residue range
    function automatic logic [63:0] bezout_of(logic [63:0] d, logic [63:0] m);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] q;
        logic [63:0] nr;
        longint      u;
        longint      w;
        longint      nu;
        x = d;
        y = m;
        u = 1;
        w = 0;
        while (y != 64'd0)
        begin
            q = x / y;
            nr = x - q * y;
            nu = u - longint'(q) * w;
            x = y;
            y = nr;
            u = w;
            w = nu;
        end
        return euclid_mod(u, m);
    endfunction

    function automatic logic [30:0] predict_residue(operand_beat_t bt, logic [30:0] modv);
        logic [63:0] m;
        logic [63:0] ra;
        logic [63:0] rb;
        logic [63:0] res;
        m = {33'd0, modv};
        if (m == 64'd0)
            return 31'd0;
        ra = euclid_mod(bt.opa, m);
        rb = euclid_mod(bt.opb, m);
        case (bt.act)
            mau_pkg::ACT_ADD: res = (ra + rb) % m;
            mau_pkg::ACT_SUB: res = (ra + m - rb) % m;
            mau_pkg::ACT_MUL: res = (ra * rb) % m;
            default:          res = (ra * bezout_of(rb, m)) % m;
        endcase
        return res[30:0];
    endfunction

    // operand mix: full range, small, extremes, multiples of the modulus and values next to it
    function automatic logic [63:0] pick_operand(logic [30:0] modv);
        logic [63:0] k;
        k = 64'($urandom_range(0, 1000));
        case ($urandom_range(0, 5))
            0, 1: return {$urandom, $urandom};
            2: return 64'(longint'($urandom_range(0, 2000)) - 1000);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 64'h8000_0000_0000_0000;
                    1: return 64'h7fff_ffff_ffff_ffff;
                    2: return 64'hffff_ffff_ffff_ffff;
                    default: return 64'd0;
                endcase
            end
            4: return ($urandom_range(0, 1) ? 64'd0 - k * modv : k * modv);
            default: return {33'd0, modv} + 64'(longint'($urandom_range(0, 2)) - 1);
        endcase
    endfunction

    task automatic queue_beat(mau_pkg::action_t act, logic [63:0] opa, logic [63:0] opb);
        operand_beat_t bt;
        bt.act = act;
        bt.opa = opa;
        bt.opb = opb;
        pending_beats.push_back(bt);
    endtask

    // wait until nothing is queued, offered or in flight and the block is idle
    task automatic wait_drained();
        @(negedge clk);
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_residues.size() != 0
               || !s_axis_tready)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_modulus(logic [30:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        modulus_copy = v;
    endtask

    // sender: offer the next pending beat, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                operand_beat_t bt;
                bt = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'd0, bt.opb, bt.opa, bt.act};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver ready, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end
        else if (hold_request)
        begin
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: predict on input beats, check on output beats
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            operand_beat_t bt;
            bt.act = mau_pkg::action_t'(s_axis_tdata[1:0]);
            bt.opa = s_axis_tdata[65:2];
            bt.opb = s_axis_tdata[129:66];
            expected_residues.push_back(predict_residue(bt, modulus_copy));
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_residues.size() == 0)
            begin
                $error("unexpected result beat, residue %0d", m_axis_tdata[30:0]);
                failures++;
            end
            else
            begin
                logic [30:0] want;
                want = expected_residues.pop_front();
                if (m_axis_tdata[30:0] !== want)
                begin
                    $error("residue mismatch: expected %0d, actual %0d", want,
                           m_axis_tdata[30:0]);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        logic [30:0] moduli[10];
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        hold_request  = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 85;
        modulus_copy  = mau_pkg::MOD_RESET;
        moduli[0] = mau_pkg::MOD_RESET;
        moduli[1] = 31'h7fff_ffff;
        moduli[2] = 31'd2;
        moduli[3] = 31'd1000000;
        moduli[4] = 31'($urandom_range(2, 32'h7fff_ffff));
        moduli[5] = 31'($urandom_range(3, 500));
        moduli[6] = 31'd0;
        moduli[7] = 31'd1;
        moduli[8] = 31'd3;
        moduli[9] = 31'($urandom_range(32'h4000_0000, 32'h7fff_fffe));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats at the reset modulus
        for (int i = 0; i < 4; i++)
        begin
            queue_beat(mau_pkg::action_t'(i), 64'h8000_0000_0000_0000,
                       64'h7fff_ffff_ffff_ffff);
            queue_beat(mau_pkg::action_t'(i), 64'hffff_ffff_ffff_ffff, 64'd1);
        end
        queue_beat(mau_pkg::ACT_ADD, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
        queue_beat(mau_pkg::ACT_SUB, 64'd0, 64'd1);
        queue_beat(mau_pkg::ACT_MUL, 64'd1000000006, 64'd1000000006);
        queue_beat(mau_pkg::ACT_DIV, 64'd5, 64'd0);
        queue_beat(mau_pkg::ACT_DIV, 64'd7, 64'd1000000007);
        queue_beat(mau_pkg::ACT_DIV, 64'd7, 64'd0 - 64'd2000000014);
        queue_beat(mau_pkg::ACT_DIV, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffe);
        queue_beat(mau_pkg::ACT_MUL, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        queue_beat(mau_pkg::ACT_DIV, 64'd1, 64'd3);

        for (int p = 0; p < 10; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                write_modulus(moduli[p]);
            end
            if (p >= 3 && p < 6)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 33;
            end
            else if (p >= 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < ITEMS_PER_SET; i++)
            begin
                // random action and operands
                queue_beat(mau_pkg::action_t'($urandom_range(0, 3)),
                           pick_operand(modulus_copy), pick_operand(modulus_copy));
                if (p == 1 && i == 20)
                begin
                    @(posedge clk);
                    hold_request <= 1'b1;
                    @(posedge clk);
                    hold_request <= 1'b0;
                end
                if (p == 2 && i == 40)
                    wait_drained();
            end
        end
        // leave the register at its full-range extreme
        wait_drained();
        write_modulus(31'h7fff_ffff);
        queue_beat(mau_pkg::ACT_DIV, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_fffe);
        wait_drained();

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
